>>> rtl/rtfr_pkg.sv
`timescale 1ns / 1ps

package rtfr_pkg;

    // Field widths of the input and result transactions
    localparam int unsigned SPACE_W  = 7;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned DEPTH_W  = 8;

    // Operation codes of the input transaction
    typedef enum logic {
        OP_SEND  = 1'b0,
        OP_EVENT = 1'b1
    } t_op;

    // Sequencer phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_START = 3'b010,
        PH_LOAD  = 3'b100
    } t_phase;

endpackage : rtfr_pkg

>>> rtl/radio_tx_fifo_refill_sequencer.sv
`timescale 1ns / 1ps

// Radio transmit FIFO refill sequencer.
// Input channel (i_in_valid / o_in_stall) carries either a send request or a
// FIFO almost-empty event, each with the free space the FIFO reports. Every
// accepted transaction yields exactly one result transaction on the output
// channel (o_out_valid / i_out_stall): reject flag, chunk offset and count,
// transmit-start pulse, underflow flag and frame-done flag.
// The result is registered at the edge that accepts the input. Throughput is
// one transaction per cycle unless the receiver stalls; the sequencer state
// (phase and read position) is updated in that same edge, so the next
// transaction sees it immediately.
// The single result register decouples the sides: a new input is taken while
// the current result is being taken in the same cycle. While the receiver
// stalls with a result pending, o_in_stall is raised and the result holds.
// Synchronous reset returns the block to idle with read position zero and no
// result pending.
module radio_tx_fifo_refill_sequencer #(
    parameter int unsigned FRAME_BYTES = 512,
    parameter int unsigned FIFO_DEPTH  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [rtfr_pkg::SPACE_W-1:0]    i_fifo_space,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_rejected,
    output logic [rtfr_pkg::OFFSET_W-1:0]   o_write_offset,
    output logic [rtfr_pkg::COUNT_W-1:0]    o_write_count,
    output logic                            o_tx_start,
    output logic                            o_underflow,
    output logic                            o_frame_done
);
    import rtfr_pkg::*;

    localparam int unsigned POS_W = $clog2(FRAME_BYTES + 1);
    localparam int unsigned CMP_W = (POS_W > SPACE_W) ? POS_W : SPACE_W;
    localparam int unsigned OFF_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
    localparam logic [POS_W-1:0]   FRAME_LEN  = POS_W'(FRAME_BYTES);
    localparam logic [DEPTH_W-1:0] FIFO_LEVEL = DEPTH_W'(FIFO_DEPTH);

    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_valid;
    logic                  r_rejected, n_rejected;
    logic [OFFSET_W-1:0]   r_offset, n_offset;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic                  r_tx_start, n_tx_start;
    logic                  r_underflow, n_underflow;
    logic                  r_done, n_done;

    logic                  in_take;
    logic                  do_begin;
    logic                  do_chunk;
    logic                  space_full;
    logic [POS_W-1:0]      base_pos;
    logic [POS_W-1:0]      remaining;
    logic [CMP_W-1:0]      remaining_ext;
    logic [CMP_W-1:0]      space_ext;
    logic [CMP_W-1:0]      pos_ext;
    logic [OFF_W-1:0]      offset_ext;

    // Accept while no result is pending or the pending one leaves now
    assign o_in_stall = r_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    // Decode the operation against the current phase
    always_comb begin
        do_begin   = 1'b0;
        do_chunk   = 1'b0;
        n_rejected = 1'b0;
        if (t_op'(i_op) == OP_SEND) begin
            if (r_phase == PH_IDLE) begin
                do_begin = 1'b1;
            end else begin
                n_rejected = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_START: do_begin = 1'b1;
                PH_LOAD:  do_chunk = 1'b1;
                default:  ;
            endcase
        end
    end

    // Size the chunk from the free space and the bytes left
    assign base_pos      = do_begin ? '0 : r_pos;
    assign remaining     = FRAME_LEN - base_pos;
    assign remaining_ext = CMP_W'(remaining);
    assign space_ext     = CMP_W'(i_fifo_space);
    assign pos_ext       = CMP_W'(base_pos) + space_ext;
    assign offset_ext    = OFF_W'(base_pos);
    assign space_full    = {1'b0, i_fifo_space} >= FIFO_LEVEL;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = base_pos;
        n_offset    = '0;
        n_count     = '0;
        n_tx_start  = 1'b0;
        n_underflow = 1'b0;
        n_done      = 1'b0;
        if (do_begin || do_chunk) begin
            if (do_chunk && space_full) begin
                // FIFO ran dry mid-frame: schedule a restart
                n_phase     = PH_START;
                n_underflow = 1'b1;
            end else begin
                n_offset   = offset_ext[OFFSET_W-1:0];
                n_tx_start = do_begin;
                if (remaining_ext > space_ext) begin
                    n_count = i_fifo_space;
                    n_pos   = pos_ext[POS_W-1:0];
                    n_phase = PH_LOAD;
                end else begin
                    n_count = remaining_ext[COUNT_W-1:0];
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
        end
    end

    // Advance sequencer state and track result occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rejected  <= n_rejected;
            r_offset    <= n_offset;
            r_count     <= n_count;
            r_tx_start  <= n_tx_start;
            r_underflow <= n_underflow;
            r_done      <= n_done;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_rejected     = r_rejected;
    assign o_write_offset = r_offset;
    assign o_write_count  = r_count;
    assign o_tx_start     = r_tx_start;
    assign o_underflow    = r_underflow;
    assign o_frame_done   = r_done;

endmodule : radio_tx_fifo_refill_sequencer

>>> rtl/rtfr_checker.sv
`timescale 1ns / 1ps

module rtfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_op,
    input logic [rtfr_pkg::SPACE_W-1:0]    i_fifo_space,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_rejected,
    input logic [rtfr_pkg::OFFSET_W-1:0]   o_write_offset,
    input logic [rtfr_pkg::COUNT_W-1:0]    o_write_count,
    input logic                            o_tx_start,
    input logic                            o_underflow,
    input logic                            o_frame_done
);
    import rtfr_pkg::*;

    // No result pending right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Hold a stalled result transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_offset)
            && $stable(o_write_count) && $stable(o_rejected))
        else $error("stalled result changed");

    // A rejected send carries no chunk and no other flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_write_count == '0 && o_write_offset == '0
            && !o_tx_start && !o_underflow && !o_frame_done)
        else $error("rejected transaction carries data");

    // Underflow writes nothing and never starts or ends a frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_underflow |-> o_write_count == '0 && o_write_offset == '0
            && !o_tx_start && !o_frame_done)
        else $error("underflow transaction carries data");

    // Transmit start only comes with the first chunk of a frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_start |-> o_write_offset == '0)
        else $error("transmit start away from frame head");

endmodule : rtfr_checker

bind radio_tx_fifo_refill_sequencer rtfr_checker u_rtfr_checker (.*);

>>> dv/radio_tx_fifo_refill_sequencer_tb.sv
`timescale 1ns / 1ps

module radio_tx_fifo_refill_sequencer_tb;
    import rtfr_pkg::*;

    localparam int unsigned FRAME_BYTES = 512;
    localparam int unsigned FIFO_DEPTH  = 64;
    localparam int unsigned ITEM_TARGET = 700;

    typedef struct packed {
        logic                rejected;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
        logic                tx_start;
        logic                underflow;
        logic                frame_done;
    } t_chunk;

    typedef struct {
        t_op                op;
        logic [SPACE_W-1:0] space;
        bit                 typed;
        t_chunk             want;
    } t_row;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_op         = 1'b0;
    logic [SPACE_W-1:0]  i_fifo_space = '0;
    logic                i_out_stall  = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_rejected;
    logic [OFFSET_W-1:0] o_write_offset;
    logic [COUNT_W-1:0]  o_write_count;
    logic                o_tx_start;
    logic                o_underflow;
    logic                o_frame_done;

    // Sequencer shadow state
    t_phase              seq_phase  = PH_IDLE;
    logic [9:0]          rd_pos     = '0;
    bit                  first_load = 1'b0;

    t_chunk              pending_chunks[$];
    t_row                dir_rows[$];
    int unsigned         mismatches = 0;
    int unsigned         items_sent = 0;
    // Long receiver hold-off: 0 none, 1 requested, 2 holding
    int                  hold_state = 0;

    radio_tx_fifo_refill_sequencer #(
        .FRAME_BYTES (FRAME_BYTES),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_fifo_space   (i_fifo_space),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rejected     (o_rejected),
        .o_write_offset (o_write_offset),
        .o_write_count  (o_write_count),
        .o_tx_start     (o_tx_start),
        .o_underflow    (o_underflow),
        .o_frame_done   (o_frame_done)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_chunk chunk_of(logic rej, int unsigned off, int unsigned cnt,
                                        logic tx, logic uf, logic fd);
        t_chunk c;
        c.rejected   = rej;
        c.offset     = OFFSET_W'(off);
        c.count      = COUNT_W'(cnt);
        c.tx_start   = tx;
        c.underflow  = uf;
        c.frame_done = fd;
        return c;
    endfunction

    // Size the next chunk from the reported free space, or flag an empty FIFO
    function automatic t_chunk next_chunk(logic [SPACE_W-1:0] space);
        t_chunk      c;
        int unsigned remaining;
        c = '0;
        remaining = FRAME_BYTES - rd_pos;
        if (space >= FIFO_DEPTH && !first_load) begin
            seq_phase   = PH_START;
            c.underflow = 1'b1;
            return c;
        end
        c.offset = rd_pos[OFFSET_W-1:0];
        if (remaining > space) begin
            c.count   = space;
            rd_pos    = rd_pos + space;
            seq_phase = PH_LOAD;
        end else begin
            c.count      = COUNT_W'(remaining);
            seq_phase    = PH_IDLE;
            c.frame_done = 1'b1;
        end
        if (first_load) begin
            first_load = 1'b0;
            c.tx_start = 1'b1;
        end
        return c;
    endfunction

    function automatic t_chunk start_frame(logic [SPACE_W-1:0] space);
        first_load = 1'b1;
        rd_pos     = '0;
        seq_phase  = PH_LOAD;
        return next_chunk(space);
    endfunction

    function automatic t_chunk refill_step(t_op op, logic [SPACE_W-1:0] space);
        t_chunk c;
        c = '0;
        if (op == OP_SEND) begin
            if (seq_phase != PH_IDLE) c.rejected = 1'b1;
            else c = start_frame(space);
        end else if (seq_phase == PH_START) begin
            c = start_frame(space);
        end else if (seq_phase == PH_LOAD) begin
            c = next_chunk(space);
        end
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Free space seen mid-frame: mostly partial, some zero, some empty FIFO
    function automatic logic [SPACE_W-1:0] mid_space();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 15) return SPACE_W'($urandom_range(FIFO_DEPTH, 127));
        return SPACE_W'($urandom_range(1, FIFO_DEPTH - 1));
    endfunction

    task automatic add_row(t_op op, int unsigned space, bit typed, t_chunk want);
        t_row row;
        row.op    = op;
        row.space = SPACE_W'(space);
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one transaction after an idle gap, hold it until taken, then predict
    task automatic send_txn(t_op op, logic [SPACE_W-1:0] space, bit typed, t_chunk want,
                            int unsigned gap);
        t_chunk pred;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_fifo_space <= space;
        do @(posedge i_clk); while (o_in_stall);
        if (!(op == OP_EVENT && seq_phase == PH_IDLE)) items_sent++;
        pred = refill_step(op, space);
        pending_chunks.push_back(typed ? want : pred);
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_chunk want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chunks.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual offset %0d count %0d",
                         $time, o_write_offset, o_write_count);
            end else begin
                want = pending_chunks.pop_front();
                check_field("rejected", want.rejected, o_rejected);
                check_field("write_offset", want.offset, o_write_offset);
                check_field("write_count", want.count, o_write_count);
                check_field("tx_start", want.tx_start, o_tx_start);
                check_field("underflow", want.underflow, o_underflow);
                check_field("frame_done", want.frame_done, o_frame_done);
            end
        end
    end

    // Receiver: random stall bursts, quiet stretches, and one long hold on request
    initial begin
        int unsigned r;
        int unsigned len;
        logic        val;
        wait (i_rst_n);
        forever begin
            if (hold_state == 1) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                hold_state = 2;
                repeat (59) @(negedge i_clk);
                hold_state = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    val = 1'b0;
                    len = $urandom_range(1, 6);
                end else if (r < 65) begin
                    val = 1'b0;
                    len = $urandom_range(40, 120);
                end else if (r < 92) begin
                    val = 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    val = 1'b1;
                    len = $urandom_range(8, 30);
                end
                @(negedge i_clk);
                i_out_stall <= val;
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Stimulus: directed rows, then random frames
    initial begin
        t_op                op;
        logic [SPACE_W-1:0] sp;
        int unsigned        frame_no;
        int unsigned        ev;
        bit                 burst;

        // Event while idle, first load with no space, rejected sends,
        // zero space mid-frame, underflow and restart, frame completion
        add_row(OP_EVENT, 0, 1'b1, chunk_of(0, 0, 0, 0, 0, 0));
        add_row(OP_EVENT, 127, 1'b1, chunk_of(0, 0, 0, 0, 0, 0));
        add_row(OP_SEND, 0, 1'b1, chunk_of(0, 0, 0, 1, 0, 0));
        add_row(OP_SEND, 64, 1'b1, chunk_of(1, 0, 0, 0, 0, 0));
        add_row(OP_EVENT, 63, 1'b0, '0);
        add_row(OP_EVENT, 0, 1'b0, '0);
        add_row(OP_EVENT, 64, 1'b1, chunk_of(0, 0, 0, 0, 1, 0));
        add_row(OP_SEND, 1, 1'b1, chunk_of(1, 0, 0, 0, 0, 0));
        add_row(OP_EVENT, 127, 1'b0, '0);
        add_row(OP_EVENT, 127, 1'b1, chunk_of(0, 0, 0, 0, 1, 0));
        add_row(OP_EVENT, 64, 1'b0, '0);
        repeat (8) add_row(OP_EVENT, 63, 1'b0, '0);
        add_row(OP_EVENT, 5, 1'b1, chunk_of(0, 0, 0, 0, 0, 0));
        add_row(OP_SEND, 127, 1'b1, chunk_of(0, 0, 127, 1, 0, 0));
        add_row(OP_EVENT, 1, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_txn(dir_rows[k].op, dir_rows[k].space, dir_rows[k].typed,
                     dir_rows[k].want, pick_gap());

        // Random frames, with some noise and a few rejected sends mid-frame
        frame_no = 0;
        while (items_sent < ITEM_TARGET) begin
            frame_no++;
            burst = ($urandom_range(0, 4) == 0);
            if (frame_no == 6) begin
                // Keep offering back to back while the receiver holds off
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                hold_state = 1;
                wait (hold_state == 2);
                burst = 1'b1;
            end
            if (frame_no == 12) begin
                // Go quiet until every expected result is out
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait (pending_chunks.size() == 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    op = t_op'($urandom_range(0, 1));
                    sp = SPACE_W'($urandom_range(0, 127));
                    send_txn(op, sp, 1'b0, '0, burst ? 0 : pick_gap());
                end
            end else begin
                sp = SPACE_W'($urandom_range(0, 127));
                send_txn(OP_SEND, sp, 1'b0, '0, burst ? 0 : pick_gap());
                ev = 0;
                while (seq_phase != PH_IDLE && ev < 60) begin
                    if ($urandom_range(0, 19) == 0) begin
                        op = OP_SEND;
                        sp = SPACE_W'($urandom_range(0, 127));
                    end else begin
                        op = OP_EVENT;
                        sp = mid_space();
                    end
                    send_txn(op, sp, 1'b0, '0, burst ? 0 : pick_gap());
                    ev++;
                end
            end
        end

        // Drain and let the last result settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_chunks.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_chunks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
